// ===== design/bbr_pkg.sv =====
// Package for the 3x3 RGB box blur: shared types, constants and the
// reciprocal table used by the rounding divide. No dependencies.
`default_nettype none

package bbr_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int WIDTH_REG_W   = 11;
   localparam int HEIGHT_W      = 16;
   localparam int ROW_W         = 17;
   localparam int CHAN_W        = 8;
   localparam int SUM_W         = 12;
   localparam int COUNT_W       = 4;
   localparam int DIVIDEND_W    = 13;
   localparam int RECIP_W       = 18;
   localparam int RECIP_SHIFT   = 18;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 16'd480;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      pixel_type above;
      pixel_type middle;
   } line_type;

   typedef struct packed {
      logic [SUM_W-1:0] blue;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] red;
   } sum_type;

   typedef struct packed {
      logic col_left;
      logic col_right;
      logic row_top;
      logic row_bottom;
      logic last;
   } mask_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_SUM
   } state_type;

   // ceil(2^18 / (2*count)), exact for every dividend below 2^13
   function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] count);
      logic [RECIP_W-1:0] m;
      begin
         case (count)
            4'd1:    m = 18'd131072;
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd6:    m = 18'd21846;
            4'd9:    m = 18'd14564;
            default: m = 18'd0;
         endcase
         return m;
      end
   endfunction

endpackage

`default_nettype wire

// ===== design/bbr_line_ram.sv =====
// Line store of the box blur: one synchronous memory holding the row above
// and the middle row per column. Uses bbr_pkg.
`default_nettype none

module bbr_line_ram #(
   parameter int DEPTH  = bbr_pkg::MAX_WIDTH_DEF,
   parameter int ADDR_W = 10
) (
   input  wire                     clock,
   input  wire                     rd_en,
   input  wire  [ADDR_W-1:0]       rd_addr,
   output bbr_pkg::line_type       rd_data,
   input  wire                     wr_en,
   input  wire  [ADDR_W-1:0]       wr_addr,
   input  bbr_pkg::line_type       wr_data
);

   bbr_pkg::line_type mem [DEPTH];
   bbr_pkg::line_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/bbr_window.sv =====
// 3x3 pixel window of the box blur with the masked per-channel sum and the
// neighbor count. Uses bbr_pkg.
`default_nettype none

module bbr_window (
   input  wire                              clock,
   input  wire                              shift_en,
   input  bbr_pkg::pixel_type               top_px,
   input  bbr_pkg::pixel_type               mid_px,
   input  bbr_pkg::pixel_type               new_px,
   input  bbr_pkg::mask_type                mask,
   output bbr_pkg::sum_type                 sum,
   output logic [bbr_pkg::COUNT_W-1:0]      count
);

   bbr_pkg::pixel_type win_ff [9];
   bbr_pkg::pixel_type win_in [9];
   logic [2:0] row_en;
   logic [2:0] col_en;
   logic [1:0] n_rows;
   logic [1:0] n_cols;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         win_in[i] = win_ff[i];
      end
      if (shift_en) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r*3]     = win_ff[r*3 + 1];
            win_in[r*3 + 1] = win_ff[r*3 + 2];
         end
         win_in[2] = top_px;
         win_in[5] = mid_px;
         win_in[8] = new_px;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 9; i++) begin
         win_ff[i] <= win_in[i];
      end
   end

   always_comb begin
      row_en = {mask.row_bottom, 1'b1, mask.row_top};
      col_en = {mask.col_right, 1'b1, mask.col_left};
      sum = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (row_en[r] && col_en[c]) begin
               sum.red   = sum.red   + bbr_pkg::SUM_W'(win_ff[r*3 + c].red);
               sum.green = sum.green + bbr_pkg::SUM_W'(win_ff[r*3 + c].green);
               sum.blue  = sum.blue  + bbr_pkg::SUM_W'(win_ff[r*3 + c].blue);
            end
         end
      end
      n_rows = 2'd1 + 2'(mask.row_top) + 2'(mask.row_bottom);
      n_cols = 2'd1 + 2'(mask.col_left) + 2'(mask.col_right);
      count  = bbr_pkg::COUNT_W'(n_rows) * bbr_pkg::COUNT_W'(n_cols);
   end

endmodule

`default_nettype wire

// ===== design/bbr_divide.sv =====
// Rounding divide of the box blur: a holding stage for sums, then a
// reciprocal multiply into the result register. Uses bbr_pkg.
`default_nettype none

module bbr_divide (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              in_valid,
   output logic                             in_ready,
   input  bbr_pkg::sum_type                 in_sum,
   input  wire  [bbr_pkg::COUNT_W-1:0]      in_count,
   input  wire                              in_last,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [23:0]                      rsp_tdata,   // out_red, out_green, out_blue
   output logic                             rsp_tlast
);

   localparam int PROD_W = bbr_pkg::DIVIDEND_W + bbr_pkg::RECIP_W;

   logic                          a_valid_ff, a_valid_in;
   bbr_pkg::sum_type              a_sum_ff;
   logic [bbr_pkg::COUNT_W-1:0]   a_count_ff;
   logic                          a_last_ff;
   logic                          out_valid_ff, out_valid_in;
   bbr_pkg::pixel_type            out_px_ff, out_px_in;
   logic                          out_last_ff;

   logic                          out_free;
   logic                          a_move;
   logic [bbr_pkg::RECIP_W-1:0]   m;
   logic [bbr_pkg::DIVIDEND_W-1:0] x_red, x_green, x_blue;
   logic [PROD_W-1:0]             p_red, p_green, p_blue;

   always_comb begin
      out_free = !out_valid_ff || rsp_tready;
      a_move   = a_valid_ff && out_free;
      in_ready = !a_valid_ff || a_move;

      m       = bbr_pkg::recip(a_count_ff);
      x_red   = {a_sum_ff.red,   1'b0} + bbr_pkg::DIVIDEND_W'(a_count_ff);
      x_green = {a_sum_ff.green, 1'b0} + bbr_pkg::DIVIDEND_W'(a_count_ff);
      x_blue  = {a_sum_ff.blue,  1'b0} + bbr_pkg::DIVIDEND_W'(a_count_ff);
      p_red   = PROD_W'(x_red)   * PROD_W'(m);
      p_green = PROD_W'(x_green) * PROD_W'(m);
      p_blue  = PROD_W'(x_blue)  * PROD_W'(m);

      out_px_in.red   = p_red  [bbr_pkg::RECIP_SHIFT +: bbr_pkg::CHAN_W];
      out_px_in.green = p_green[bbr_pkg::RECIP_SHIFT +: bbr_pkg::CHAN_W];
      out_px_in.blue  = p_blue [bbr_pkg::RECIP_SHIFT +: bbr_pkg::CHAN_W];

      a_valid_in = (in_valid && in_ready) || (a_valid_ff && !a_move);
      out_valid_in = a_move || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         a_sum_ff   <= in_sum;
         a_count_ff <= in_count;
         a_last_ff  <= in_last;
      end
      if (a_move) begin
         out_px_ff   <= out_px_in;
         out_last_ff <= a_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_px_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// ===== design/box_blur_3x3_rgb_core.sv =====
// Top level of the 3x3 RGB box blur: request control, position tracking,
// configuration registers. Uses bbr_pkg, bbr_line_ram, bbr_window, bbr_divide.
//
// Pixels enter in raster order and leave as the rounded per-channel mean of
// their existing 3x3 neighbors, width+1 requests behind the input; width+1
// drain requests (req_tuser high) after the frame flush the rest, and the
// final pixel carries rsp_tlast. A pixel or drain that does work passes the
// line-store read, then shift and write-back, and the window sum when it
// produces a result (held until the divide takes it); an out-of-place request
// is accepted and dropped in idle. The result then passes the divide stages,
// which hold up to two results while rsp_tready is low. The line store needs no
// clearing after reset. A configuration write restarts the frame.
`default_nettype none

module box_blur_3x3_rgb_core #(
   parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [23:0]                         req_tdata,   // in_red, in_green, in_blue
   input  wire                                 req_tuser,   // kind
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [23:0]                         rsp_tdata,   // out_red, out_green, out_blue
   output logic                                rsp_tlast,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [bbr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [bbr_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W = (WW > bbr_pkg::WIDTH_REG_W) ? WW : bbr_pkg::WIDTH_REG_W;
   localparam int ROW_W = bbr_pkg::ROW_W;

   logic [bbr_pkg::WIDTH_REG_W-1:0] width_ff, width_in;
   logic [bbr_pkg::HEIGHT_W-1:0]    height_ff, height_in;
   logic [COL_W-1:0]                col_ff, col_in;
   logic [ROW_W-1:0]                row_ff, row_in;
   bbr_pkg::state_type              state_ff, state_in;
   bbr_pkg::pixel_type              px_ff, px_in;
   logic [COL_W-1:0]                idx_ff, idx_in;
   logic                            emit_ff, emit_in;
   bbr_pkg::mask_type               mask_ff, mask_in;

   logic [CMP_W-1:0]                eff_w;
   logic [CMP_W-1:0]                width_ext;
   logic [ROW_W-1:0]                eff_h;
   logic [COL_W-1:0]                col_cur;
   logic [CMP_W-1:0]                col_next;
   logic                            accept;
   logic                            ignore;
   logic                            zero_col;
   logic                            emit_now;
   bbr_pkg::mask_type               mask_now;
   logic                            mem_rd;
   logic                            mem_wr;
   bbr_pkg::line_type               mem_rdata;
   bbr_pkg::line_type               mem_wdata;
   logic                            shift_en;
   logic                            sum_valid;
   logic                            sum_ready;
   bbr_pkg::sum_type                win_sum;
   logic [bbr_pkg::COUNT_W-1:0]     win_count;

   // effective frame size and current column
   always_comb begin
      width_ext = CMP_W'(width_ff);
      if (width_ff == '0) begin
         eff_w = CMP_W'(1);
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         eff_w = CMP_W'(MAX_WIDTH);
      end else begin
         eff_w = width_ext;
      end
      eff_h   = (height_ff == '0) ? ROW_W'(1) : ROW_W'(height_ff);
      col_cur = (CMP_W'(col_ff) >= eff_w) ? '0 : col_ff;
   end

   // request classification and neighbor mask
   always_comb begin
      ignore   = req_tuser ? (row_ff < eff_h) : (row_ff >= eff_h);
      zero_col = (col_cur == '0);
      mask_now = '0;
      if (zero_col) begin
         emit_now            = (row_ff >= ROW_W'(2)) && ((row_ff - ROW_W'(2)) < eff_h);
         mask_now.col_left   = (eff_w >= CMP_W'(2));
         mask_now.col_right  = 1'b0;
         mask_now.row_top    = (row_ff >= ROW_W'(3));
         mask_now.row_bottom = (row_ff - ROW_W'(1)) < eff_h;
         mask_now.last       = (row_ff == eff_h + ROW_W'(1));
      end else begin
         emit_now            = (row_ff >= ROW_W'(1)) && ((row_ff - ROW_W'(1)) < eff_h);
         mask_now.col_left   = (col_cur >= COL_W'(2));
         mask_now.col_right  = 1'b1;
         mask_now.row_top    = (row_ff >= ROW_W'(2));
         mask_now.row_bottom = (row_ff < eff_h);
         mask_now.last       = 1'b0;
      end
      col_next = CMP_W'(col_cur) + CMP_W'(1);
   end

   // control sequence, position and configuration
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      mem_rd     = 1'b0;
      mem_wr     = 1'b0;
      shift_en   = 1'b0;
      sum_valid  = 1'b0;
      col_in     = col_ff;
      row_in     = row_ff;
      px_in      = px_ff;
      idx_in     = idx_ff;
      emit_in    = emit_ff;
      mask_in    = mask_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      accept     = 1'b0;
      csr_ready  = 1'b1;

      case (state_ff)
         bbr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            if (accept && !ignore) begin
               mem_rd   = 1'b1;
               px_in    = req_tuser ? '0 : bbr_pkg::pixel_type'(req_tdata);
               idx_in   = col_cur;
               emit_in  = emit_now;
               mask_in  = mask_now;
               state_in = bbr_pkg::ST_SHIFT;
               if (emit_now && mask_now.last) begin
                  col_in = '0;
                  row_in = '0;
               end else if (col_next >= eff_w) begin
                  col_in = '0;
                  row_in = row_ff + ROW_W'(1);
               end else begin
                  col_in = col_next[COL_W-1:0];
               end
            end
         end
         bbr_pkg::ST_SHIFT: begin
            mem_wr   = 1'b1;
            shift_en = 1'b1;
            state_in = emit_ff ? bbr_pkg::ST_SUM : bbr_pkg::ST_IDLE;
         end
         bbr_pkg::ST_SUM: begin
            sum_valid = 1'b1;
            if (sum_ready) begin
               state_in = bbr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bbr_pkg::ST_IDLE;
         end
      endcase

      if (csr_valid) begin
         case (csr_index)
            bbr_pkg::CSR_FRAME_WIDTH: begin
               width_in = csr_data[bbr_pkg::WIDTH_REG_W-1:0];
               col_in   = '0;
               row_in   = '0;
            end
            bbr_pkg::CSR_FRAME_HEIGHT: begin
               height_in = csr_data;
               col_in    = '0;
               row_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bbr_pkg::ST_IDLE;
         width_ff  <= bbr_pkg::WIDTH_RESET;
         height_ff <= bbr_pkg::HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff   <= px_in;
      idx_ff  <= idx_in;
      emit_ff <= emit_in;
      mask_ff <= mask_in;
   end

   assign mem_wdata = {mem_rdata.middle, px_ff};

   bbr_line_ram #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
   ) u_line_ram (
      .clock   (clock),
      .rd_en   (mem_rd),
      .rd_addr (col_cur),
      .rd_data (mem_rdata),
      .wr_en   (mem_wr),
      .wr_addr (idx_ff),
      .wr_data (mem_wdata)
   );

   bbr_window u_window (
      .clock    (clock),
      .shift_en (shift_en),
      .top_px   (mem_rdata.above),
      .mid_px   (mem_rdata.middle),
      .new_px   (px_ff),
      .mask     (mask_ff),
      .sum      (win_sum),
      .count    (win_count)
   );

   bbr_divide u_divide (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (sum_valid),
      .in_ready   (sum_ready),
      .in_sum     (win_sum),
      .in_count   (win_count),
      .in_last    (mask_ff.last),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== tb/sv/box_blur_3x3_rgb_core_tb.sv =====
// Self-checking testbench for box_blur_3x3_rgb_core: streams framed pixel and drain
// requests, predicts every blurred pixel and compares each one as it leaves the block.
// Depends on bbr_pkg and the box_blur_3x3_rgb_core RTL.
module box_blur_3x3_rgb_core_tb;
   import bbr_pkg::*;

   localparam int MAX_COLS = MAX_WIDTH_DEF;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum bit {KIND_PIXEL = 1'b0, KIND_DRAIN = 1'b1} req_kind;

   typedef struct {
      req_kind   kind;
      pixel_type px;
   } blur_req;

   typedef struct packed {
      pixel_type px;
      logic      last;
   } blur_result;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // blur predictor state
   logic [WIDTH_REG_W-1:0] cfg_width = WIDTH_RESET;
   logic [HEIGHT_W-1:0] cfg_height = HEIGHT_RESET;
   pixel_type row_above [MAX_COLS] = '{default: '0};
   pixel_type row_middle [MAX_COLS] = '{default: '0};
   pixel_type win [9] = '{default: '0};
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;
   int unsigned out_count = 0;

   blur_req req_backlog[$];
   blur_result blurred_expected[$];
   logic req_accepted = 1'b0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int holds_asked = 0;
   int holds_served = 0;
   int hold_left = 0;
   int errors = 0;
   int reqs_taken = 0;
   int pixels_checked = 0;
   int frames_done = 0;
   int reg_writes = 0;
   int unsigned offered_items = 0;

   box_blur_3x3_rgb_core uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   function automatic int unsigned frame_cols(input logic [WIDTH_REG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_COLS) return MAX_COLS;
      return v;
   endfunction

   function automatic pixel_type window_mean(input int cc, input bit left, input bit right,
                                             input bit top, input bit bottom);
      int unsigned sr, sg, sb, n;
      pixel_type m;
      sr = 0;
      sg = 0;
      sb = 0;
      n = 0;
      for (int r = 0; r < 3; r++) begin
         if ((r == 0 && !top) || (r == 2 && !bottom)) continue;
         for (int c = cc - 1; c <= cc + 1; c++) begin
            if ((c == cc - 1 && !left) || (c == cc + 1 && !right) || c < 0 || c > 2) continue;
            sr += win[r*3+c].red;
            sg += win[r*3+c].green;
            sb += win[r*3+c].blue;
            n++;
         end
      end
      if (n == 0) n = 1;
      m.red = 8'((2*sr + n) / (2*n));
      m.green = 8'((2*sg + n) / (2*n));
      m.blue = 8'((2*sb + n) / (2*n));
      return m;
   endfunction

   function automatic void load_register(input logic [CSR_INDEX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_FRAME_WIDTH: cfg_width = data[WIDTH_REG_W-1:0];
         CSR_FRAME_HEIGHT: cfg_height = data;
         default: return;
      endcase
      col_pos = 0;
      row_pos = 0;
      out_count = 0;
   endfunction

   function automatic bit blur_predict(input bit drain, input pixel_type px_in,
                                       output blur_result res);
      int unsigned w, h, total, r, c;
      pixel_type px, above, middle;
      bit fired;
      w = frame_cols(cfg_width);
      h = (cfg_height == 0) ? 1 : cfg_height;
      total = w * h;
      r = row_pos;
      c = col_pos;
      fired = 0;
      res = '0;
      if (drain ? (r < h) : (r >= h)) return 0;
      if (c >= w) c = 0;
      px = drain ? '0 : px_in;
      // at column zero the target is the last pixel of row r-2, taken before the shift
      if (c == 0 && r >= 2 && r - 2 < h && out_count < total) begin
         res.px = window_mean(2, w >= 2, 1'b0, r >= 3, r - 1 < h);
         fired = 1;
      end
      above = row_above[c];
      middle = row_middle[c];
      for (int k = 0; k < 3; k++) begin
         win[k*3] = win[k*3+1];
         win[k*3+1] = win[k*3+2];
      end
      win[2] = above;
      win[5] = middle;
      win[8] = px;
      row_above[c] = middle;
      row_middle[c] = px;
      if (c != 0 && r >= 1 && r - 1 < h && out_count < total) begin
         res.px = window_mean(1, c >= 2, 1'b1, r >= 2, r < h);
         fired = 1;
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
      end
      col_pos = c;
      row_pos = r;
      if (!fired) return 0;
      out_count++;
      res.last = (out_count >= total);
      if (res.last) begin
         col_pos = 0;
         row_pos = 0;
         out_count = 0;
      end
      return 1;
   endfunction

   function automatic pixel_type random_pixel();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return 24'($urandom);
      endcase
   endfunction

   // request driver
   always @(negedge clock) begin
      blur_req item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_accepted) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= item.px;
            req_tuser <= item.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready, with long hold-offs on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (holds_asked != holds_served) begin
         rsp_tready <= 1'b0;
         hold_left = 300;
         holds_served = holds_served + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // predict on accepted requests, check accepted results
   always @(posedge clock) begin
      blur_result got, want, res;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         req_accepted <= req_tvalid && req_tready;
         if (csr_valid && csr_ready) begin
            load_register(csr_index, csr_data);
            reg_writes++;
         end
         if (req_tvalid && req_tready) begin
            reqs_taken++;
            if (blur_predict(req_tuser == KIND_DRAIN, req_tdata, res))
               blurred_expected.push_back(res);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.px = rsp_tdata;
            got.last = rsp_tlast;
            if (blurred_expected.size() == 0) begin
               errors++;
               if (errors <= 100)
                  $display("%0t: unexpected pixel, expected none, got r %0d g %0d b %0d last %0b",
                           $time, got.px.red, got.px.green, got.px.blue, got.last);
            end else begin
               want = blurred_expected.pop_front();
               pixels_checked++;
               if (want.last) frames_done++;
               if (got.px.red !== want.px.red || got.px.green !== want.px.green ||
                   got.px.blue !== want.px.blue || got.last !== want.last) begin
                  errors++;
                  if (errors <= 100)
                     $display("%0t: pixel mismatch, expected r %0d g %0d b %0d last %0b, %s",
                              $time, want.px.red, want.px.green, want.px.blue, want.last,
                              $sformatf("got r %0d g %0d b %0d last %0b", got.px.red,
                                        got.px.green, got.px.blue, got.last));
               end
            end
         end
      end
   end

   task automatic push_req(input req_kind k, input pixel_type p, input bit counted);
      blur_req item;
      item.kind = k;
      item.px = p;
      req_backlog.push_back(item);
      if (counted) offered_items++;
   endtask

   task automatic wait_quiet();
      do @(posedge clock);
      while (req_backlog.size() != 0 || req_tvalid || blurred_expected.size() != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_frame(input logic [CSR_DATA_W-1:0] wd, input logic [CSR_DATA_W-1:0] hd,
                            input bit set_w, input bit set_h, input bit noisy,
                            input bit pause_mid);
      int unsigned w, h, cut;
      w = frame_cols(wd[WIDTH_REG_W-1:0]);
      h = (hd == 0) ? 1 : hd;
      if (set_w || set_h) wait_quiet();
      if (set_w) write_register(CSR_FRAME_WIDTH, wd);
      if (set_h) write_register(CSR_FRAME_HEIGHT, hd);
      cut = (noisy && $urandom_range(24) == 0) ? $urandom_range(w*h - 1) : w*h;
      for (int unsigned n = 0; n < cut; n++) begin
         if (noisy && $urandom_range(99) < 4) push_req(KIND_DRAIN, random_pixel(), 0);
         push_req(KIND_PIXEL, random_pixel(), 1);
         if (pause_mid && n == w*h/2) wait_quiet();
      end
      if (cut != w*h) return;
      if (noisy && $urandom_range(2) == 0) push_req(KIND_PIXEL, random_pixel(), 0);
      repeat (w + 1) push_req(KIND_DRAIN, random_pixel(), 1);
      if (noisy && $urandom_range(2) == 0) push_req(KIND_DRAIN, random_pixel(), 0);
   endtask

   task automatic random_frames(input int unsigned target);
      int unsigned start;
      logic [CSR_DATA_W-1:0] wd, hd, cur_wd, cur_hd;
      logic [1:0] mode;
      bit first;
      start = offered_items;
      first = 1;
      cur_wd = 16'd1;
      cur_hd = 16'd1;
      while (offered_items - start < target) begin
         mode = first ? 2'b11 : 2'($urandom_range(3));
         case ($urandom_range(9))
            0: wd = 16'($urandom_range(2));
            1, 2: wd = 16'($urandom_range(40, 9));
            default: wd = 16'($urandom_range(8, 1));
         endcase
         if ($urandom_range(9) == 0) wd[CSR_DATA_W-1:WIDTH_REG_W] = 5'($urandom);
         hd = ($urandom_range(11) == 0) ? 16'd0 : 16'($urandom_range(5, 1));
         if (mode[0]) cur_wd = wd;
         if (mode[1]) cur_hd = hd;
         run_frame(cur_wd, cur_hd, mode[0], mode[1], 1, 0);
         first = 0;
      end
   endtask

   initial begin
      pixel_type p;
      int idle_tbl [4] = '{0, 80, 0, 28};
      int stall_tbl [4] = '{0, 0, 80, 28};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one-pixel frame from zero-valued registers, with ignored extra pixel and drain
      write_register(CSR_FRAME_WIDTH, 16'd0);
      write_register(CSR_FRAME_HEIGHT, 16'd0);
      push_req(KIND_PIXEL, '1, 1);
      push_req(KIND_PIXEL, random_pixel(), 1);
      push_req(KIND_DRAIN, '0, 1);
      push_req(KIND_DRAIN, '1, 1);
      push_req(KIND_DRAIN, random_pixel(), 1);
      wait_quiet();

      // 3x3 frame of extreme channels, early drain in the middle
      write_register(CSR_FRAME_WIDTH, 16'd3);
      write_register(CSR_FRAME_HEIGHT, 16'd3);
      for (int i = 0; i < 9; i++) begin
         p.red = (i % 2) ? 8'd255 : 8'd0;
         p.green = (i % 3 == 0) ? 8'd255 : 8'd0;
         p.blue = 8'(i * 28 + 31);
         push_req(KIND_PIXEL, p, 1);
         if (i == 4) push_req(KIND_DRAIN, '1, 1);
      end
      repeat (4) push_req(KIND_DRAIN, random_pixel(), 1);
      wait_quiet();

      // one column, tallest frame, left unfinished
      write_register(CSR_FRAME_WIDTH, 16'd1);
      write_register(CSR_FRAME_HEIGHT, 16'hFFFF);
      repeat (3) push_req(KIND_PIXEL, random_pixel(), 1);
      wait_quiet();

      // clamped widest frame into its second row, with a write to an unused index in between
      write_register(CSR_FRAME_WIDTH, 16'hFFFF);
      write_register(CSR_FRAME_HEIGHT, 16'd2);
      push_req(KIND_PIXEL, random_pixel(), 1);
      wait_quiet();
      write_register(CSR_SPARE, 16'($urandom));
      repeat (MAX_COLS + 3) push_req(KIND_PIXEL, random_pixel(), 1);

      for (int phase = 0; phase < 4; phase++) begin
         wait_quiet();
         send_idle_pct = idle_tbl[phase];
         stall_pct = stall_tbl[phase];
         if (phase == 0) begin
            run_frame(16'd40, 16'd4, 1, 1, 0, 0);
            holds_asked++;
         end
         if (phase == 1) run_frame(16'd6, 16'd5, 1, 1, 1, 1);
         random_frames(80);
      end

      wait_quiet();
      $display("run: %0d requests, %0d register writes, %0d blurred pixels checked",
               reqs_taken, reg_writes, pixels_checked);
      $display("run: %0d frames ended across idle, stall and hold-off phases", frames_done);
      if (errors == 0) begin
         $display("box_blur_3x3_rgb_core_tb passed");
      end else begin
         $display("box_blur_3x3_rgb_core_tb failed");
      end
      $finish;
   end

   initial begin
      #6000000;
      $display("timeout with %0d results outstanding", blurred_expected.size());
      $display("box_blur_3x3_rgb_core_tb failed");
      $finish;
   end

endmodule
